// ===== sv/adp_pkg.sv =====
// Types and constants shared by the ASCII decimal number parser modules.
`default_nettype none

package adp_pkg;

    // ASCII codes the classifier looks for
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    localparam int MAG_OUT_BITS = 32;
    localparam int FRAC_BITS    = 6;
    localparam logic [FRAC_BITS-1:0] FRAC_MAX = 6'd63;

    localparam int CLS_QUEUE_DEPTH = 4;
    localparam int RES_QUEUE_DEPTH = 2;

    typedef enum logic [2:0] {
        CLS_DIGIT,
        CLS_DOT,
        CLS_PLUS,
        CLS_MINUS,
        CLS_END,
        CLS_OTHER
    } cls_kind_t;

    typedef struct packed {
        cls_kind_t   kind;
        logic [3:0]  digit;
    } cls_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_PARSE = 2'd1,
        ST_OVER  = 2'd2
    } status_t;

    typedef struct packed {
        status_t                  status;
        logic                     negative;
        logic [MAG_OUT_BITS-1:0]  magnitude;
        logic [FRAC_BITS-1:0]     frac_digits;
    } res_t;

endpackage

`default_nettype wire

// ===== sv/adp_queue.sv =====
// Small first-in first-out queue of fixed-width requests.
`default_nettype none

module adp_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             empty
);

    // DEPTH must be a power of two so the pointers wrap on their own
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entries [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rd_data = entries[rd_ptr_reg];
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_wr)
        begin
            wr_ptr_next = wr_ptr_reg + PW'(1);
        end
        if (do_rd)
        begin
            rd_ptr_next = rd_ptr_reg + PW'(1);
        end
        if (do_wr && !do_rd)
        begin
            count_next = count_reg + CW'(1);
        end
        else if (do_rd && !do_wr)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            entries[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("queue count above depth");

    a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(full && empty))
        else $error("queue full and empty at once");

    a_pop_lowers: assert property (@(posedge clk) disable iff (!rst_n)
        (do_rd && !do_wr) |=> (count_reg == $past(count_reg) - CW'(1)))
        else $error("queue count did not drop on read");

endmodule

`default_nettype wire

// ===== sv/adp_front.sv =====
// Front end: takes input bytes and classifies them into parser requests.
`default_nettype none

module adp_front (
    input  logic          push,
    input  logic [7:0]    char_in,
    output logic          full,
    input  logic          q_full,
    output logic          q_wr,
    output adp_pkg::cls_t q_data
);
    import adp_pkg::*;

    logic [7:0] digit_off;

    assign full      = q_full;
    assign q_wr      = push && !q_full;
    assign digit_off = char_in - CH_ZERO;

    always_comb
    begin
        q_data.digit = digit_off[3:0];
        if (char_in == CH_NUL)
        begin
            q_data.kind = CLS_END;
        end
        else if (char_in == CH_DOT)
        begin
            q_data.kind = CLS_DOT;
        end
        else if (char_in == CH_PLUS)
        begin
            q_data.kind = CLS_PLUS;
        end
        else if (char_in == CH_MINUS)
        begin
            q_data.kind = CLS_MINUS;
        end
        else if (char_in >= CH_ZERO && char_in <= CH_NINE)
        begin
            q_data.kind = CLS_DIGIT;
        end
        else
        begin
            q_data.kind = CLS_OTHER;
        end
    end

endmodule

`default_nettype wire

// ===== sv/adp_back.sv =====
// Back end: runs the parse state on classified requests and queues results.
`default_nettype none

module adp_back #(
    parameter int MAG_BITS = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cls_valid,
    input  adp_pkg::cls_t        cls,
    output logic                 cls_pop,
    input  logic                 pop,
    output logic                 empty,
    output adp_pkg::res_t        res
);
    import adp_pkg::*;

    localparam int SW = MAG_BITS + 4;

    logic                 at_start_reg, at_start_next;
    logic                 neg_reg, neg_next;
    logic                 body_reg, body_next;
    logic                 dot_reg, dot_next;
    logic                 err_reg, err_next;
    logic                 over_reg, over_next;
    logic [MAG_BITS-1:0]  acc_reg, acc_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;

    logic [SW-1:0]        prod_sum;
    logic                 res_push, res_full;
    res_t                 res_data;

    // acc * 10 + digit; anything in the top four bits is past the limit
    assign prod_sum = SW'({acc_reg, 3'b000}) + SW'({acc_reg, 1'b0}) + SW'(cls.digit);

    always_comb
    begin
        at_start_next = at_start_reg;
        neg_next      = neg_reg;
        body_next     = body_reg;
        dot_next      = dot_reg;
        err_next      = err_reg;
        over_next     = over_reg;
        acc_next      = acc_reg;
        frac_next     = frac_reg;
        cls_pop       = 1'b0;
        res_push      = 1'b0;
        res_data      = '0;
        res_data.status = ST_OK;

        // hold a terminator until the result queue has room
        if (cls_valid && (cls.kind != CLS_END || !res_full))
        begin
            cls_pop = 1'b1;
            if (cls.kind == CLS_END)
            begin
                res_push = 1'b1;
                if (err_reg || !body_reg)
                begin
                    res_data.status = ST_PARSE;
                end
                else
                begin
                    res_data.status      = over_reg ? ST_OVER : ST_OK;
                    res_data.negative    = neg_reg;
                    res_data.magnitude   = MAG_OUT_BITS'(acc_reg);
                    res_data.frac_digits = frac_reg;
                end
                at_start_next = 1'b1;
                neg_next      = 1'b0;
                body_next     = 1'b0;
                dot_next      = 1'b0;
                err_next      = 1'b0;
                over_next     = 1'b0;
                acc_next      = '0;
                frac_next     = '0;
            end
            else if (err_reg)
            begin
                // drop everything up to the terminator
                at_start_next = 1'b0;
            end
            else if (at_start_reg && cls.kind == CLS_MINUS)
            begin
                at_start_next = 1'b0;
                neg_next      = 1'b1;
            end
            else if (at_start_reg && cls.kind == CLS_PLUS)
            begin
                at_start_next = 1'b0;
            end
            else
            begin
                at_start_next = 1'b0;
                case (cls.kind)
                    CLS_DOT:
                    begin
                        if (dot_reg)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            dot_next  = 1'b1;
                            body_next = 1'b1;
                        end
                    end
                    CLS_DIGIT:
                    begin
                        body_next = 1'b1;
                        if (prod_sum[SW-1 -: 4] != 4'd0)
                        begin
                            acc_next  = '1;
                            over_next = 1'b1;
                        end
                        else
                        begin
                            acc_next = prod_sum[MAG_BITS-1:0];
                        end
                        if (dot_reg)
                        begin
                            if (frac_reg == FRAC_MAX)
                            begin
                                over_next = 1'b1;
                            end
                            else
                            begin
                                frac_next = frac_reg + FRAC_BITS'(1);
                            end
                        end
                    end
                    default:
                    begin
                        err_next = 1'b1;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            at_start_reg <= 1'b1;
            neg_reg      <= 1'b0;
            body_reg     <= 1'b0;
            dot_reg      <= 1'b0;
            err_reg      <= 1'b0;
            over_reg     <= 1'b0;
            acc_reg      <= '0;
            frac_reg     <= '0;
        end
        else
        begin
            at_start_reg <= at_start_next;
            neg_reg      <= neg_next;
            body_reg     <= body_next;
            dot_reg      <= dot_next;
            err_reg      <= err_next;
            over_reg     <= over_next;
            acc_reg      <= acc_next;
            frac_reg     <= frac_next;
        end
    end

    adp_queue #(
        .WIDTH ($bits(res_t)),
        .DEPTH (RES_QUEUE_DEPTH)
    ) u_res_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (res_push),
        .wr_data (res_data),
        .full    (res_full),
        .rd_en   (pop),
        .rd_data (res),
        .empty   (empty)
    );

    a_frac_needs_dot: assert property (@(posedge clk) disable iff (!rst_n)
        (frac_reg != '0) |-> dot_reg)
        else $error("fraction digits counted without a dot");

    a_err_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        err_reg |-> !at_start_reg)
        else $error("parse error flagged before first byte");

    a_acc_needs_body: assert property (@(posedge clk) disable iff (!rst_n)
        (acc_reg != '0) |-> body_reg)
        else $error("digits accumulated without a body");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        res_push |=> (at_start_reg && !err_reg && !body_reg && acc_reg == '0))
        else $error("state not cleared after terminator");

endmodule

`default_nettype wire

// ===== sv/ascii_decimal_number_parser.sv =====
// Top level of the ASCII decimal number parser.
//
//   channel   ports                                         handshake
//   input     char_in[7:0]                                  push / full
//   result    status[1:0] negative magnitude[31:0]          empty / pop
//             frac_digits[5:0]
//
// Takes one byte per cycle while full is low; each digit byte is one step of
// a shift-add by ten in the back end. A terminator's result is queued and
// reaches the result ports once earlier results are popped. Reset returns
// the parse state to the start of a string and empties both queues. A
// stalled result side blocks only terminators in the back end; bytes keep
// flowing until the 4-entry request queue fills, which raises full.
`default_nettype none

module ascii_decimal_number_parser #(
    parameter int MAG_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  char_in,
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  status,
    output logic        negative,
    output logic [31:0] magnitude,
    output logic [5:0]  frac_digits
);
    import adp_pkg::*;

    logic  q_full, q_wr, q_empty, q_rd;
    cls_t  q_wdata, q_rdata;
    res_t  res;

    adp_front u_front (
        .push    (push),
        .char_in (char_in),
        .full    (full),
        .q_full  (q_full),
        .q_wr    (q_wr),
        .q_data  (q_wdata)
    );

    adp_queue #(
        .WIDTH ($bits(cls_t)),
        .DEPTH (CLS_QUEUE_DEPTH)
    ) u_cls_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_wr),
        .wr_data (q_wdata),
        .full    (q_full),
        .rd_en   (q_rd),
        .rd_data (q_rdata),
        .empty   (q_empty)
    );

    adp_back #(
        .MAG_BITS (MAG_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls_valid (!q_empty),
        .cls       (q_rdata),
        .cls_pop   (q_rd),
        .pop       (pop),
        .empty     (empty),
        .res       (res)
    );

    assign status      = res.status;
    assign negative    = res.negative;
    assign magnitude   = res.magnitude;
    assign frac_digits = res.frac_digits;

endmodule

`default_nettype wire
